// File: src/pcso_pkg.sv
// ----------------------------------------------------------------------------
// pcso_pkg: shared types, constants and functions
// Register map, queue item layout and the quarter-wave sine generator used
// to build the oscillator's lookup table.
// ----------------------------------------------------------------------------
package pcso_pkg;

	localparam int TABLE_BITS_DEF = 10;
	localparam int PHASE_BITS_DEF = 32;

	localparam int PRESSURE_BITS = 12;
	localparam int HZ_BITS       = 15;
	localparam int STEP_BITS     = 24;
	localparam int AMP_BITS      = 15;
	localparam int SAMPLE_BITS   = 16;
	localparam int ROM_BITS      = 15;

	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 24;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FREQ_MIN  = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FREQ_SPAN = 4'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEP      = 4'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE = 4'd3;

	localparam logic [HZ_BITS-1:0]   FREQ_MIN_RST  = 15'd100;
	localparam logic [HZ_BITS-1:0]   FREQ_SPAN_RST = 15'd900;
	localparam logic [STEP_BITS-1:0] STEP_RST      = 24'd97392;
	localparam logic [AMP_BITS-1:0]  AMPLITUDE_RST = 15'd16384;

	// Divide by full-scale pressure (2^12 - 1) one base-4096 digit at a time.
	localparam int DIGIT_BITS  = 12;
	localparam logic [DIGIT_BITS-1:0] PRESSURE_FULL = 12'd4095;
	localparam int PROD1_BITS  = PRESSURE_BITS + HZ_BITS;
	localparam int NUM_BITS    = PROD1_BITS + STEP_BITS;
	localparam int DIV_DIGITS  = (NUM_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int DIV_BITS    = DIV_DIGITS * DIGIT_BITS;
	localparam int BASE_BITS   = HZ_BITS + STEP_BITS;

	localparam int QUEUE_DEPTH     = 2;
	localparam int QUEUE_PTR_BITS  = 1;
	localparam int QUEUE_CNT_BITS  = 2;

	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_START_ON,
		KIND_START_OFF
	} item_kind_t;

	typedef struct packed {
		item_kind_t                kind;
		logic [PRESSURE_BITS-1:0]  pressure;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	typedef struct packed {
		logic [HZ_BITS-1:0]   freq_min_hz;
		logic [HZ_BITS-1:0]   freq_span_hz;
		logic [STEP_BITS-1:0] step_per_hz;
		logic [AMP_BITS-1:0]  amplitude;
	} cfg_t;

	// Magnitude of sin(pi/2 * x), x in Q30 over [0, 1], as saturated Q0.15.
	// Only ever called with constant arguments to build the lookup table.
	function automatic logic [ROM_BITS-1:0] quarter_sine(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] p;
		x2 = (x * x) >> 30;
		p  = 64'd5026995 - ((x2 * 64'd172272) >> 30);
		p  = 64'd85569306 - ((x2 * p) >> 30);
		p  = 64'd693598668 - ((x2 * p) >> 30);
		p  = 64'd1686629713 - ((x2 * p) >> 30);
		p  = (x * p) >> 30;
		p  = (p + 64'd16384) >> 15;
		if (p > 64'd32767) begin
			p = 64'd32767;
		end
		return p[ROM_BITS-1:0];
	endfunction

endpackage

// File: src/pcso_front.sv
// ----------------------------------------------------------------------------
// pcso_front: input classification and item queue
// Accepts input beats, sorts each into plain sample, block start with the
// gate on, or block start with the gate off, and queues it for the back end.
// ----------------------------------------------------------------------------
module pcso_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  block_start,
	input  logic [pcso_pkg::PRESSURE_BITS-1:0]    pressure,
	input  logic                                  note_on,
	output pcso_pkg::queue_head_t                 head,
	input  logic                                  pop
);

	pcso_pkg::item_t                          entry_q [pcso_pkg::QUEUE_DEPTH];
	logic [pcso_pkg::QUEUE_PTR_BITS-1:0]      wr_ptr_q;
	logic [pcso_pkg::QUEUE_PTR_BITS-1:0]      rd_ptr_q;
	logic [pcso_pkg::QUEUE_CNT_BITS-1:0]      count_q;
	pcso_pkg::item_t                          new_item;
	logic                                     push;
	logic                                     take;

	always_comb begin
		if (!block_start) begin
			new_item.kind = pcso_pkg::KIND_SAMPLE;
		end else if (note_on) begin
			new_item.kind = pcso_pkg::KIND_START_ON;
		end else begin
			new_item.kind = pcso_pkg::KIND_START_OFF;
		end
		new_item.pressure = pressure;
	end

	assign in_stall   = (count_q == pcso_pkg::QUEUE_CNT_BITS'(pcso_pkg::QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign take       = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

endmodule

// File: src/pcso_back.sv
// ----------------------------------------------------------------------------
// pcso_back: increment computation and sample synthesis
// Sequencer: recomputes the phase increment on a note-on block start, looks up
// the quarter-wave sine table, scales by amplitude and holds the result beat.
// ----------------------------------------------------------------------------
module pcso_back #(
	parameter int TABLE_BITS = pcso_pkg::TABLE_BITS_DEF,
	parameter int PHASE_BITS = pcso_pkg::PHASE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pcso_pkg::cfg_t                        cfg,
	input  pcso_pkg::queue_head_t                 head,
	output logic                                  pop,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [pcso_pkg::SAMPLE_BITS-1:0] sample
);

	localparam int POS_BITS = TABLE_BITS - 1;
	localparam int Q_BITS   = TABLE_BITS - 2;
	localparam int QUARTER  = 2 ** Q_BITS;
	localparam int DB       = pcso_pkg::DIGIT_BITS;
	localparam int DCNT_BITS = $clog2(pcso_pkg::DIV_DIGITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_SUM,
		ST_SCALE
	} state_t;

	state_t                                  state_q;
	logic                                    gate_q;
	logic [PHASE_BITS-1:0]                   phase_acc_q;
	logic [PHASE_BITS-1:0]                   phase_step_q;
	logic [pcso_pkg::PRESSURE_BITS-1:0]      pressure_q;
	logic [pcso_pkg::PROD1_BITS-1:0]         prod1_q;
	logic [pcso_pkg::BASE_BITS-1:0]          base_q;
	logic [pcso_pkg::DIV_BITS-1:0]           num_q;
	logic [DB-1:0]                           rem_q;
	logic [PHASE_BITS-1:0]                   quot_q;
	logic [DCNT_BITS-1:0]                    dcnt_q;
	logic [pcso_pkg::ROM_BITS-1:0]           rom_q;
	logic                                    neg_q;
	logic                                    out_valid_q;
	logic signed [pcso_pkg::SAMPLE_BITS-1:0] sample_q;

	logic [pcso_pkg::ROM_BITS-1:0]           rom_w [QUARTER+1];
	logic [TABLE_BITS-1:0]                   idx;
	logic [POS_BITS-1:0]                     pos;
	logic [DB-1:0]                           digit;
	logic [DB:0]                             dsum;
	logic                                    dcarry;
	logic [DB-1:0]                           rem_next;
	logic [DB-1:0]                           qdigit;
	logic [PHASE_BITS-1:0]                   step_next;
	logic [2*pcso_pkg::AMP_BITS-1:0]         scaled;
	logic [pcso_pkg::SAMPLE_BITS-1:0]        mag;
	logic                                    out_free;

	for (genvar i = 0; i <= QUARTER; i++) begin : g_rom
		assign rom_w[i] = pcso_pkg::quarter_sine(64'(i) << (30 - Q_BITS));
	end

	// Quadrants 1 and 3 read the table backward; 2 and 3 are negated.
	assign idx = phase_acc_q[PHASE_BITS-1 -: TABLE_BITS];
	assign pos = idx[TABLE_BITS-2] ? (POS_BITS'(QUARTER) - {1'b0, idx[Q_BITS-1:0]})
	                               : {1'b0, idx[Q_BITS-1:0]};

	// One base-4096 digit per cycle: with remainder r and digit d, the
	// quotient digit is r plus one carry when r + d reaches 4095.
	assign digit    = num_q[pcso_pkg::DIV_BITS-1 -: DB];
	assign dsum     = {1'b0, rem_q} + {1'b0, digit};
	assign dcarry   = (dsum >= {1'b0, pcso_pkg::PRESSURE_FULL});
	assign rem_next = dcarry ? DB'(dsum - {1'b0, pcso_pkg::PRESSURE_FULL}) : dsum[DB-1:0];
	assign qdigit   = rem_q + DB'(dcarry);

	assign step_next = base_q[PHASE_BITS-1:0] + quot_q;

	assign scaled   = (2*pcso_pkg::AMP_BITS)'(cfg.amplitude) * (2*pcso_pkg::AMP_BITS)'(rom_q);
	assign mag      = {1'b0, scaled[2*pcso_pkg::AMP_BITS-1 -: pcso_pkg::AMP_BITS]};
	assign out_free = !out_valid_q || !out_stall;

	assign pop       = (state_q == ST_IDLE) && head.valid;
	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			gate_q       <= 1'b0;
			phase_acc_q  <= '0;
			phase_step_q <= '0;
			pressure_q   <= '0;
			prod1_q      <= '0;
			base_q       <= '0;
			num_q        <= '0;
			rem_q        <= '0;
			quot_q       <= '0;
			dcnt_q       <= '0;
			rom_q        <= '0;
			neg_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			sample_q     <= '0;
		end else begin
			// In ST_SCALE the output register is loaded below instead.
			if (out_valid_q && !out_stall && state_q != ST_SCALE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						pressure_q <= head.item.pressure;
						case (head.item.kind)
							pcso_pkg::KIND_START_ON: begin
								gate_q  <= 1'b1;
								state_q <= ST_MUL1;
							end
							pcso_pkg::KIND_START_OFF: begin
								gate_q  <= 1'b0;
								rom_q   <= '0;
								neg_q   <= 1'b0;
								state_q <= ST_SCALE;
							end
							default: begin
								if (gate_q) begin
									rom_q       <= rom_w[pos];
									neg_q       <= idx[TABLE_BITS-1];
									phase_acc_q <= phase_acc_q + phase_step_q;
								end else begin
									rom_q <= '0;
									neg_q <= 1'b0;
								end
								state_q <= ST_SCALE;
							end
						endcase
					end
				end
				ST_MUL1: begin
					prod1_q <= pcso_pkg::PROD1_BITS'(pressure_q) *
					           pcso_pkg::PROD1_BITS'(cfg.freq_span_hz);
					base_q  <= pcso_pkg::BASE_BITS'(cfg.freq_min_hz) *
					           pcso_pkg::BASE_BITS'(cfg.step_per_hz);
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					num_q   <= pcso_pkg::DIV_BITS'(
					           pcso_pkg::NUM_BITS'(prod1_q) *
					           pcso_pkg::NUM_BITS'(cfg.step_per_hz));
					rem_q   <= '0;
					quot_q  <= '0;
					dcnt_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					num_q  <= num_q << DB;
					rem_q  <= rem_next;
					quot_q <= {quot_q[PHASE_BITS-DB-1:0], qdigit};
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_BITS'(pcso_pkg::DIV_DIGITS - 1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					phase_step_q <= step_next;
					rom_q        <= rom_w[pos];
					neg_q        <= idx[TABLE_BITS-1];
					phase_acc_q  <= phase_acc_q + step_next;
					state_q      <= ST_SCALE;
				end
				ST_SCALE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						sample_q    <= neg_q ? -$signed(mag) : $signed(mag);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/pressure_controlled_sine_oscillator.sv
// ----------------------------------------------------------------------------
// pressure_controlled_sine_oscillator: pressure-controlled DDS sine source
// Each input beat requests one signed audio sample from a phase accumulator
// and a quarter-wave sine table.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries block_start, pressure and
// note_on; every accepted beat yields exactly one sample beat on the output
// channel (out_valid, out_stall). A beat with block_start latches note_on as
// the gate; with the gate on it also recomputes the phase increment as
// freq_min_hz*step_per_hz + pressure*freq_span_hz*step_per_hz/4095.
// Plain sample beats pass through a table read, then the amplitude
// multiply, in the back end, which takes the next beat only after the
// current sample is loaded into the output register. A block start with
// the gate on first runs two multiply steps, a digit-serial divide by
// 4095 and the increment add. A two-entry queue decouples input
// acceptance from synthesis.
// Reset clears phase, increment and gate (silent) and loads the register
// defaults. While out_stall is high the finished beat holds and the queue
// keeps filling until it is full, then in_stall rises.
// Registers are written through cfg_we/cfg_index/cfg_wdata; unknown indexes
// are ignored.
// ----------------------------------------------------------------------------
module pressure_controlled_sine_oscillator #(
	parameter int TABLE_BITS = pcso_pkg::TABLE_BITS_DEF,
	parameter int PHASE_BITS = pcso_pkg::PHASE_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [pcso_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  logic [pcso_pkg::CFG_DATA_BITS-1:0]       cfg_wdata,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic                                     block_start,
	input  logic [pcso_pkg::PRESSURE_BITS-1:0]       pressure,
	input  logic                                     note_on,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [pcso_pkg::SAMPLE_BITS-1:0]  sample
);

	pcso_pkg::cfg_t        cfg_q;
	pcso_pkg::queue_head_t head;
	logic                  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freq_min_hz  <= pcso_pkg::FREQ_MIN_RST;
			cfg_q.freq_span_hz <= pcso_pkg::FREQ_SPAN_RST;
			cfg_q.step_per_hz  <= pcso_pkg::STEP_RST;
			cfg_q.amplitude    <= pcso_pkg::AMPLITUDE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pcso_pkg::REG_FREQ_MIN: begin
					cfg_q.freq_min_hz <= cfg_wdata[pcso_pkg::HZ_BITS-1:0];
				end
				pcso_pkg::REG_FREQ_SPAN: begin
					cfg_q.freq_span_hz <= cfg_wdata[pcso_pkg::HZ_BITS-1:0];
				end
				pcso_pkg::REG_STEP: begin
					cfg_q.step_per_hz <= cfg_wdata[pcso_pkg::STEP_BITS-1:0];
				end
				pcso_pkg::REG_AMPLITUDE: begin
					cfg_q.amplitude <= cfg_wdata[pcso_pkg::AMP_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	pcso_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.block_start (block_start),
		.pressure    (pressure),
		.note_on     (note_on),
		.head        (head),
		.pop         (pop)
	);

	pcso_back #(
		.TABLE_BITS (TABLE_BITS),
		.PHASE_BITS (PHASE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample    (sample)
	);

endmodule
